// ===== design/rate_pid_with_actual_rates_defines.svh =====
// Assertion macros for the rate controller checker.
`ifndef RATE_PID_WITH_ACTUAL_RATES_DEFINES_SVH
`define RATE_PID_WITH_ACTUAL_RATES_DEFINES_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define RPAR_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst_sig is high.
`define RPAR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpar_pkg.sv =====
// Shared types, constants and helpers for the rate controller.
`default_nettype none
package rpar_pkg;

  localparam int NUM_AXES   = 3;
  localparam int DVD_W      = 52;
  localparam int DVS_W      = 20;
  localparam logic [DVS_W-1:0] MICRO = 20'd1000000;
  localparam logic [31:0]      MAX_S32 = 32'h7fff_ffff;

  // floor(2^59 / 15625) + 1: exact quotient by 15625 for dividends below 2^45
  localparam logic [45:0]      RECIP_15625 = 46'd36893488147420;
  // 500000 / 64, the rounding offset once the divisor 1e6 has lost its 2^6
  localparam logic [45:0]      HALF_15625  = 46'd7812;

  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_MAXR   = 3'd1;
  localparam logic [2:0] REG_EXPO   = 3'd2;
  localparam logic [2:0] REG_KP     = 3'd3;
  localparam logic [2:0] REG_KI     = 3'd4;
  localparam logic [2:0] REG_KD     = 3'd5;
  localparam logic [2:0] REG_LIMITS = 3'd6;
  localparam logic [2:0] REG_INVERT = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SKIP, OP_ABS, OP_A2, OP_A4, OP_A6, OP_F1, OP_F2,
    OP_T1, OP_T2, OP_ERR, OP_IMUL, OP_ISTEP, OP_DMUL, OP_P, OP_DLO, OP_DHI,
    OP_DADD, OP_IACC, OP_OUT, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_SKIP, ST_ABS, ST_A2, ST_A4, ST_A6, ST_F1, ST_F2,
    ST_T1, ST_T2, ST_ERR, ST_IMUL, ST_IWAIT, ST_ISTEP, ST_DMUL, ST_DWAIT,
    ST_P, ST_DLO, ST_DHI, ST_DADD, ST_IACC, ST_OUT, ST_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] lane(input logic [47:0] r, input logic [1:0] ax);
    logic [15:0] v;
    unique case (ax)
      2'd0:    v = r[15:0];
      2'd1:    v = r[31:16];
      default: v = r[47:32];
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/rpar_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module rpar_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rpar_pkg::DVD_W-1:0]      dividend,
  input  wire logic [rpar_pkg::DVS_W-1:0]      divisor,
  output logic      [rpar_pkg::DVD_W-1:0]      quotient,
  output logic                                 done
);
  logic [rpar_pkg::DVD_W-1:0] qd;
  logic [rpar_pkg::DVS_W-1:0] rem;
  logic [rpar_pkg::DVS_W-1:0] dvs;
  logic [5:0]                 cnt;
  logic                       busy;
  logic [rpar_pkg::DVS_W:0]   trial;
  logic                       fits;

  assign trial    = {rem, qd[rpar_pkg::DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(rpar_pkg::DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qd  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      qd <= {qd[rpar_pkg::DVD_W-2:0], fits};
      if (fits) begin
        rem <= rpar_pkg::DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[rpar_pkg::DVS_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/rpar_dpath.sv =====
// Datapath: configuration, state, per-axis arithmetic and the result register.
`default_nettype none
module rpar_dpath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rpar_pkg::cmd_t  cmd,
  output rpar_pkg::sts_t       sts,
  input  wire logic [127:0]    in_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_idx,
  input  wire logic [63:0]     cfg_wdata,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [95:0]          out_data,
  output logic                 out_flag
);
  logic [47:0] center, maxr, expo, kp_r, ki_r, kd_r;
  logic [63:0] lim;
  logic [2:0]  inv;

  logic signed [15:0] stick [3];
  logic signed [19:0] meas  [3];
  logic [15:0]        dt;

  logic signed [31:0] integ [3];
  logic signed [23:0] lerr  [3];

  logic               sneg, dneg, skipped;
  logic [15:0]        a, a2, a4, a6, f;
  logic [33:0]        p;
  logic signed [23:0] tgt, err;
  logic [63:0]        dprod;
  logic signed [63:0] acc;
  logic [31:0]        outs [3];

  logic [15:0] c, mx, e, kp, ki, kd;
  logic [1:0]  ax;
  logic [16:0] ecomp;
  logic [33:0] f2sum, t2sum;
  logic [15:0] mov;
  logic [22:0] mag;
  logic signed [23:0] m24, meff, err_next, lerr_sel;
  logic [23:0] errmag;
  logic [39:0] edt;
  logic signed [24:0] diff;
  logic [24:0] dmag;
  logic [44:0] dm;
  logic        div_start, div_done;
  logic [rpar_pkg::DVD_W-1:0] dvd, quo;
  logic [rpar_pkg::DVS_W-1:0] dvs;
  logic signed [35:0] stepv, isum, ibs, iclamp;
  logic signed [31:0] integ_sel;
  logic [31:0] ib, ab;
  logic signed [40:0] pprod;
  logic [47:0] dlo;
  logic [29:0] dhi;
  logic signed [48:0] iprod, ishift;
  logic signed [63:0] rnd, abs64, rclamp;

  logic [45:0] rc_n;
  logic [91:0] rc_acc, rc_term;
  logic [1:0]  rc_cnt;
  logic        rc_busy, rc_done;
  logic [22:0] rc_a, rc_b;
  logic [45:0] rc_pp;

  assign ax = cmd.ax;
  assign c  = rpar_pkg::lane(center, ax);
  assign mx = rpar_pkg::lane(maxr, ax);
  assign e  = rpar_pkg::lane(expo, ax);
  assign kp = rpar_pkg::lane(kp_r, ax);
  assign ki = rpar_pkg::lane(ki_r, ax);
  assign kd = rpar_pkg::lane(kd_r, ax);

  // actual-rates curve
  assign ecomp = 17'd65536 - {1'b0, e};
  assign f2sum = p + 34'(a2) * 34'(ecomp);
  assign mov   = (mx > c) ? 16'(mx - c) : 16'd0;
  assign t2sum = p + 34'(mov) * 34'(f) + 34'd1024;
  assign mag   = t2sum[33:11];

  assign m24      = {{4{meas[ax][19]}}, meas[ax]};
  assign meff     = inv[ax] ? -m24 : m24;
  assign err_next = tgt - meff;

  // integral step: (|err| * dt * 4096 + 500000) / 1e6, taken as
  // (|err| * dt * 64 + 7812) / 15625 by a reciprocal multiply
  assign errmag = err[23] ? 24'(-err) : 24'(err);
  assign edt    = 40'(errmag) * 40'(dt);

  assign rc_a  = rc_cnt[1] ? rc_n[45:23] : rc_n[22:0];
  assign rc_b  = rc_cnt[0] ? rpar_pkg::RECIP_15625[45:23] : rpar_pkg::RECIP_15625[22:0];
  assign rc_pp = 46'(rc_a) * 46'(rc_b);

  always_comb begin
    unique case (rc_cnt)
      2'd0:    rc_term = {46'd0, rc_pp};
      2'd3:    rc_term = {rc_pp, 46'd0};
      default: rc_term = {23'd0, rc_pp, 23'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_busy <= 1'b0;
      rc_done <= 1'b0;
      rc_cnt  <= '0;
    end else if (cmd.op == rpar_pkg::OP_IMUL) begin
      rc_busy <= 1'b1;
      rc_done <= 1'b0;
      rc_cnt  <= '0;
    end else if (rc_busy) begin
      rc_cnt <= rc_cnt + 2'd1;
      if (rc_cnt == 2'd3) begin
        rc_busy <= 1'b0;
        rc_done <= 1'b1;
      end
    end else begin
      rc_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rpar_pkg::OP_IMUL) begin
      rc_n   <= {edt, 6'd0} + rpar_pkg::HALF_15625;
      rc_acc <= '0;
    end else if (rc_busy) begin
      rc_acc <= rc_acc + rc_term;
    end
  end

  assign lerr_sel = lerr[ax];
  assign diff     = {err[23], err} - {lerr_sel[23], lerr_sel};
  assign dmag     = diff[24] ? 25'(-diff) : 25'(diff);
  assign dm       = 45'(dmag) * 45'(rpar_pkg::MICRO);

  assign div_start = (cmd.op == rpar_pkg::OP_DMUL);
  assign dvd = {7'd0, dm};
  assign dvs = {4'd0, dt};

  rpar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  assign integ_sel = integ[ax];
  assign stepv  = err[23] ? -$signed({3'b000, rc_acc[91:59]})
                          : $signed({3'b000, rc_acc[91:59]});
  assign isum   = {{4{integ_sel[31]}}, integ_sel} + stepv;
  assign ib     = lim[31] ? rpar_pkg::MAX_S32 : lim[31:0];
  assign ibs    = $signed({4'd0, ib});
  assign iclamp = (isum > ibs) ? ibs : ((isum < -ibs) ? -ibs : isum);

  assign pprod  = err * $signed({1'b0, kp});
  assign dlo    = 48'(quo[31:0]) * 48'(kd);
  assign dhi    = 30'(quo[45:32]) * 30'(kd);
  assign iprod  = integ_sel * $signed({1'b0, ki});
  assign ishift = iprod >>> 12;

  assign rnd    = (acc + 64'sd128) >>> 8;
  assign ab     = lim[63] ? rpar_pkg::MAX_S32 : lim[63:32];
  assign abs64  = $signed({32'd0, ab});
  assign rclamp = (rnd > abs64) ? abs64 : ((rnd < -abs64) ? -abs64 : rnd);

  assign sts.dt_zero  = (dt == 16'd0);
  assign sts.div_done = div_done || rc_done;
  assign sts.out_free = !out_valid || out_ready;

  // configuration, controller state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0; maxr <= '0; expo <= '0;
      kp_r <= '0; ki_r <= '0; kd_r <= '0;
      lim <= '0; inv <= '0;
      for (int i = 0; i < rpar_pkg::NUM_AXES; i++) begin
        integ[i] <= '0;
        lerr[i]  <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          rpar_pkg::REG_CENTER: center <= cfg_wdata[47:0];
          rpar_pkg::REG_MAXR:   maxr   <= cfg_wdata[47:0];
          rpar_pkg::REG_EXPO:   expo   <= cfg_wdata[47:0];
          rpar_pkg::REG_KP:     kp_r   <= cfg_wdata[47:0];
          rpar_pkg::REG_KI:     ki_r   <= cfg_wdata[47:0];
          rpar_pkg::REG_KD:     kd_r   <= cfg_wdata[47:0];
          rpar_pkg::REG_LIMITS: lim    <= cfg_wdata;
          rpar_pkg::REG_INVERT: inv    <= cfg_wdata[2:0];
        endcase
      end
      if (cmd.op == rpar_pkg::OP_ISTEP) begin
        integ[ax] <= iclamp[31:0];
      end
      if (cmd.op == rpar_pkg::OP_DMUL) begin
        lerr[ax] <= err;
      end
      if (cmd.op == rpar_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rpar_pkg::OP_LOAD: begin
        stick[0] <= in_data[15:0];
        stick[1] <= in_data[31:16];
        stick[2] <= in_data[47:32];
        meas[0]  <= in_data[67:48];
        meas[1]  <= in_data[87:68];
        meas[2]  <= in_data[107:88];
        dt       <= in_data[123:108];
        skipped  <= 1'b0;
      end
      rpar_pkg::OP_SKIP: begin
        for (int i = 0; i < rpar_pkg::NUM_AXES; i++) outs[i] <= '0;
        skipped <= 1'b1;
      end
      rpar_pkg::OP_ABS: begin
        sneg <= stick[ax][15];
        a    <= stick[ax][15] ? 16'(~stick[ax] + 16'sd1) : 16'(stick[ax]);
      end
      rpar_pkg::OP_A2:  a2 <= 16'((32'(a) * 32'(a)) >> 15);
      rpar_pkg::OP_A4:  a4 <= 16'((32'(a2) * 32'(a2)) >> 15);
      rpar_pkg::OP_A6:  a6 <= 16'((32'(a4) * 32'(a2)) >> 15);
      rpar_pkg::OP_F1:  p  <= 34'(a6) * 34'(e);
      rpar_pkg::OP_F2:  f  <= f2sum[31:16];
      rpar_pkg::OP_T1:  p  <= 34'(a) * 34'(c);
      rpar_pkg::OP_T2:  tgt <= sneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      rpar_pkg::OP_ERR: err <= err_next;
      rpar_pkg::OP_DMUL: dneg <= diff[24];
      rpar_pkg::OP_P:   acc <= {{23{pprod[40]}}, pprod};
      rpar_pkg::OP_DLO: dprod <= {16'd0, dlo};
      rpar_pkg::OP_DHI: dprod <= dprod + {2'd0, dhi, 32'd0};
      rpar_pkg::OP_DADD: acc <= dneg ? acc - $signed(dprod) : acc + $signed(dprod);
      rpar_pkg::OP_IACC: acc <= acc + {{15{ishift[48]}}, ishift};
      rpar_pkg::OP_OUT:  outs[ax] <= rclamp[31:0];
      rpar_pkg::OP_EMIT: begin
        out_data <= {outs[2], outs[1], outs[0]};
        out_flag <= skipped;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/rpar_ctrl.sv =====
// Sequencer: steps the datapath through the three axes of one tick, or skips a zero-dt tick.
`default_nettype none
module rpar_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rpar_pkg::sts_t  sts,
  output rpar_pkg::cmd_t       cmd
);
  rpar_pkg::state_t state, state_next;
  logic [1:0]       ax, ax_next;
  logic             last_ax;

  assign last_ax = (ax == 2'(rpar_pkg::NUM_AXES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpar_pkg::ST_IDLE;
      ax    <= '0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    unique case (state)
      rpar_pkg::ST_IDLE: if (in_valid) begin
        state_next = rpar_pkg::ST_CHECK;
        ax_next    = '0;
      end
      rpar_pkg::ST_CHECK: state_next = sts.dt_zero ? rpar_pkg::ST_SKIP : rpar_pkg::ST_ABS;
      rpar_pkg::ST_SKIP:  state_next = rpar_pkg::ST_EMIT;
      rpar_pkg::ST_ABS:   state_next = rpar_pkg::ST_A2;
      rpar_pkg::ST_A2:    state_next = rpar_pkg::ST_A4;
      rpar_pkg::ST_A4:    state_next = rpar_pkg::ST_A6;
      rpar_pkg::ST_A6:    state_next = rpar_pkg::ST_F1;
      rpar_pkg::ST_F1:    state_next = rpar_pkg::ST_F2;
      rpar_pkg::ST_F2:    state_next = rpar_pkg::ST_T1;
      rpar_pkg::ST_T1:    state_next = rpar_pkg::ST_T2;
      rpar_pkg::ST_T2:    state_next = rpar_pkg::ST_ERR;
      rpar_pkg::ST_ERR:   state_next = rpar_pkg::ST_IMUL;
      rpar_pkg::ST_IMUL:  state_next = rpar_pkg::ST_IWAIT;
      rpar_pkg::ST_IWAIT: if (sts.div_done) state_next = rpar_pkg::ST_ISTEP;
      rpar_pkg::ST_ISTEP: state_next = rpar_pkg::ST_DMUL;
      rpar_pkg::ST_DMUL:  state_next = rpar_pkg::ST_DWAIT;
      rpar_pkg::ST_DWAIT: if (sts.div_done) state_next = rpar_pkg::ST_P;
      rpar_pkg::ST_P:     state_next = rpar_pkg::ST_DLO;
      rpar_pkg::ST_DLO:   state_next = rpar_pkg::ST_DHI;
      rpar_pkg::ST_DHI:   state_next = rpar_pkg::ST_DADD;
      rpar_pkg::ST_DADD:  state_next = rpar_pkg::ST_IACC;
      rpar_pkg::ST_IACC:  state_next = rpar_pkg::ST_OUT;
      rpar_pkg::ST_OUT: begin
        if (last_ax) begin
          state_next = rpar_pkg::ST_EMIT;
        end else begin
          state_next = rpar_pkg::ST_ABS;
          ax_next    = ax + 2'd1;
        end
      end
      rpar_pkg::ST_EMIT: if (sts.out_free) state_next = rpar_pkg::ST_IDLE;
      default: state_next = rpar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.ax   = ax;
    cmd.op   = rpar_pkg::OP_NONE;
    unique case (state)
      rpar_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = rpar_pkg::OP_LOAD;
      end
      rpar_pkg::ST_SKIP:  cmd.op = rpar_pkg::OP_SKIP;
      rpar_pkg::ST_ABS:   cmd.op = rpar_pkg::OP_ABS;
      rpar_pkg::ST_A2:    cmd.op = rpar_pkg::OP_A2;
      rpar_pkg::ST_A4:    cmd.op = rpar_pkg::OP_A4;
      rpar_pkg::ST_A6:    cmd.op = rpar_pkg::OP_A6;
      rpar_pkg::ST_F1:    cmd.op = rpar_pkg::OP_F1;
      rpar_pkg::ST_F2:    cmd.op = rpar_pkg::OP_F2;
      rpar_pkg::ST_T1:    cmd.op = rpar_pkg::OP_T1;
      rpar_pkg::ST_T2:    cmd.op = rpar_pkg::OP_T2;
      rpar_pkg::ST_ERR:   cmd.op = rpar_pkg::OP_ERR;
      rpar_pkg::ST_IMUL:  cmd.op = rpar_pkg::OP_IMUL;
      rpar_pkg::ST_ISTEP: cmd.op = rpar_pkg::OP_ISTEP;
      rpar_pkg::ST_DMUL:  cmd.op = rpar_pkg::OP_DMUL;
      rpar_pkg::ST_P:     cmd.op = rpar_pkg::OP_P;
      rpar_pkg::ST_DLO:   cmd.op = rpar_pkg::OP_DLO;
      rpar_pkg::ST_DHI:   cmd.op = rpar_pkg::OP_DHI;
      rpar_pkg::ST_DADD:  cmd.op = rpar_pkg::OP_DADD;
      rpar_pkg::ST_IACC:  cmd.op = rpar_pkg::OP_IACC;
      rpar_pkg::ST_OUT:   cmd.op = rpar_pkg::OP_OUT;
      rpar_pkg::ST_EMIT:  if (sts.out_free) cmd.op = rpar_pkg::OP_EMIT;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/rate_pid_with_actual_rates.sv =====
// A tick with zero dt skips the axis arithmetic and returns zeros flagged as skipped.
// Each axis passes through the 52-bit radix-2 divider (derivative by dt) and the
// reciprocal multiply of the integral step; requests are taken one at a time.
// The next request is taken once the result has moved into the output register.
// Synchronous reset clears configuration, integrals, last errors and the sequencer.
// Configuration writes are always accepted and take effect on the next cycle.
`default_nettype none
module rate_pid_with_actual_rates (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // stick_roll, stick_pitch, stick_yaw, meas_roll, meas_pitch, meas_yaw, dt_us, pad
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accel_roll, accel_pitch, accel_yaw
  output logic [95:0]       m_axis_tdata,
  // skipped
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  rpar_pkg::cmd_t cmd;
  rpar_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rpar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpar_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );
endmodule
`default_nettype wire

// ===== design/rpar_checker.sv =====
// Port-level checks for the rate controller, bound to the top level.
`default_nettype none
`include "rate_pid_with_actual_rates_defines.svh"
module rpar_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [95:0]  m_axis_tdata,
  input wire logic         m_axis_tuser
);
  `RPAR_ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `RPAR_ASSERT_SAME(a_skip_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 96'd0, "skipped tick with nonzero output")
  `RPAR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")
  `RPAR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
endmodule

bind rate_pid_with_actual_rates rpar_checker u_rpar_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for the three-axis actual-rates PID controller.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic        skip;
  } accel_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  rate_pid_with_actual_rates u_dut (.*);

  always #5 clk = ~clk;

  // controller shadow state
  logic [63:0] shadow_reg [8];
  longint      integ [3];
  longint      prev_err [3];

  logic [127:0] tick_q [$];
  accel_t       accel_q [$];
  int  errors = 0;
  int  n_ticks = 0;
  int  n_results = 0;
  int  n_skips = 0;
  int  idle_cycles = 0;
  bit  rx_hold = 1'b0;

  function automatic longint fshift(longint x, int n);
    if (x >= 0) return x >>> n;
    return -((-x + (64'sd1 << n) - 1) >>> n);
  endfunction

  function automatic longint csym(longint x, longint b);
    if (x > b) return b;
    if (x < -b) return -b;
    return x;
  endfunction

  function automatic longint shaped_rate(longint s, int ax);
    longint unsigned c, mx, e, a, a2, a4, a6, f, mov, mag;
    c  = shadow_reg[rpar_pkg::REG_CENTER][16*ax +: 16];
    mx = shadow_reg[rpar_pkg::REG_MAXR][16*ax +: 16];
    e  = shadow_reg[rpar_pkg::REG_EXPO][16*ax +: 16];
    a  = s < 0 ? -s : s;
    a2 = (a * a) >> 15;
    a4 = (a2 * a2) >> 15;
    a6 = (a4 * a2) >> 15;
    f  = (a6 * e + a2 * (65536 - e)) >> 16;
    mov = mx > c ? mx - c : 0;
    mag = (a * c + mov * f + 1024) >> 11;
    return s < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic accel_t pid_tick(logic [127:0] d);
    accel_t r;
    longint ib, ab, s, meas, err, stp, der, sum, acc;
    longint unsigned dt, mag;
    logic [31:0] o [3];
    r = '0;
    dt = d[108 +: 16];
    if (dt == 0) begin
      r.skip = 1'b1;
      return r;
    end
    ib = shadow_reg[rpar_pkg::REG_LIMITS][31:0];
    if (ib > rpar_pkg::MAX_S32) ib = rpar_pkg::MAX_S32;
    ab = shadow_reg[rpar_pkg::REG_LIMITS][63:32];
    if (ab > rpar_pkg::MAX_S32) ab = rpar_pkg::MAX_S32;
    for (int ax = 0; ax < 3; ax++) begin
      s = $signed(d[16*ax +: 16]);
      meas = $signed(d[48 + 20*ax +: 20]);
      if (shadow_reg[rpar_pkg::REG_INVERT][ax]) meas = -meas;
      err = shaped_rate(s, ax) - meas;
      mag = longint'(err < 0 ? -err : err) * dt * 4096;
      mag = (mag + 500000) / 1000000;
      stp = err < 0 ? -longint'(mag) : longint'(mag);
      integ[ax] = csym(integ[ax] + stp, ib);
      der = ((err - prev_err[ax]) * 1000000) / longint'(dt);
      prev_err[ax] = err;
      sum = err * longint'(shadow_reg[rpar_pkg::REG_KP][16*ax +: 16])
          + der * longint'(shadow_reg[rpar_pkg::REG_KD][16*ax +: 16])
          + fshift(integ[ax] * longint'(shadow_reg[rpar_pkg::REG_KI][16*ax +: 16]), 12);
      acc = csym(fshift(sum + 128, 8), ab);
      o[ax] = acc[31:0];
    end
    r.roll = o[0];
    r.pitch = o[1];
    r.yaw = o[2];
    return r;
  endfunction

  function automatic logic [127:0] pack_tick(logic [15:0] sr, logic [15:0] sp,
      logic [15:0] sy, logic [19:0] mr, logic [19:0] mp, logic [19:0] my,
      logic [15:0] dt);
    return {4'd0, dt, my, mp, mr, sy, sp, sr};
  endfunction

  function automatic logic [15:0] rnd_stick();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] rnd_meas();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2: return 20'($urandom_range(0, 4000)) - 20'd2000;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_dt();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'd1;
      default: return 16'($urandom_range(100, 5000));
    endcase
  endfunction

  function automatic logic [63:0] rnd64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // driver: random gaps, long ones now and then
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        accel_q.push_back(pid_tick(s_axis_tdata));
        n_ticks++;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        s_axis_tdata <= tick_q.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) :
                 ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int rx_gap = 0;
  always @(posedge clk) begin
    accel_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = {m_axis_tdata, m_axis_tuser};
      if (accel_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = accel_q.pop_front();
        if (got.skip) n_skips++;
        if (got.roll !== want.roll)
          begin $display("%0t: roll exp %h got %h", $time, want.roll, got.roll); errors++; end
        if (got.pitch !== want.pitch)
          begin $display("%0t: pitch exp %h got %h", $time, want.pitch, got.pitch); errors++; end
        if (got.yaw !== want.yaw)
          begin $display("%0t: yaw exp %h got %h", $time, want.yaw, got.yaw); errors++; end
        if (got.skip !== want.skip)
          begin $display("%0t: skip exp %b got %b", $time, want.skip, got.skip); errors++; end
      end
    end
    if (rst || rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 500) : $urandom_range(0, 4);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst || rx_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drain();
    while (tick_q.size() > 0 || s_axis_tvalid || accel_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rpar_pkg::REG_INVERT) shadow_reg[idx] = val & 64'h7;
    else if (idx == rpar_pkg::REG_LIMITS) shadow_reg[idx] = val;
    else shadow_reg[idx] = val & 64'hffff_ffff_ffff;
    // the extra wait keeps the next request off this edge
    @(posedge clk);
  endtask

  task automatic program_all(int mode);
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: write_reg(3'(i), '0);
        1: write_reg(3'(i), '1);
        default: begin
          if (i == rpar_pkg::REG_LIMITS)
            write_reg(3'(i), {1'b0, 31'($urandom_range(0, 1 << 24)),
                              1'b0, 31'($urandom)});
          else if (i >= rpar_pkg::REG_KP && i <= rpar_pkg::REG_KD)
            write_reg(3'(i), {16'd0, 16'($urandom_range(0, 1024)),
                              16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024))});
          else
            write_reg(3'(i), rnd64());
        end
      endcase
    end
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++)
      tick_q.push_back(pack_tick(rnd_stick(), rnd_stick(), rnd_stick(),
                                 rnd_meas(), rnd_meas(), rnd_meas(), rnd_dt()));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    for (int i = 0; i < 3; i++) begin integ[i] = 0; prev_err[i] = 0; end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, then realistic, then all-ones extremes
    tick_q.push_back(pack_tick(16'h7fff, 16'h8000, 16'h0, 20'h7ffff, 20'h80000, 20'h0, 16'd1000));
    wait_drain();
    program_all(2);
    write_reg(rpar_pkg::REG_INVERT, 64'h5);
    tick_q.push_back(pack_tick(16'h7fff, 16'h8000, 16'h0, 20'h7ffff, 20'h80000, 20'h0, 16'd1000));
    tick_q.push_back(pack_tick(16'h8000, 16'h7fff, 16'hffff, 20'h1, 20'hfffff, 20'h80000, 16'd0));
    tick_q.push_back(pack_tick(16'h4000, 16'hc000, 16'h0001, 20'h100, 20'h0, 20'h7ffff, 16'd1));
    tick_q.push_back(pack_tick(16'h7fff, 16'h7fff, 16'h7fff, 20'h80000, 20'h80000, 20'h80000,
                               16'hffff));
    tick_q.push_back(pack_tick(16'h8000, 16'h8000, 16'h8000, 20'h7ffff, 20'h7ffff, 20'h7ffff,
                               16'd1));
    wait_drain();
    program_all(1);
    tick_q.push_back(pack_tick(16'h7fff, 16'h8000, 16'h1234, 20'h7ffff, 20'h80000, 20'h0, 16'd1));
    tick_q.push_back(pack_tick(16'h8000, 16'h7fff, 16'h0, 20'h80000, 20'h7ffff, 20'h1, 16'hffff));
    tick_q.push_back(pack_tick(16'h0, 16'h0, 16'h0, 20'h0, 20'h0, 20'h0, 16'd0));
    add_random(10);
    wait_drain();

    // long receiver hold while the sender keeps offering
    add_random(20);
    rx_hold = 1'b1;
    repeat (2000) @(posedge clk);
    rx_hold = 1'b0;
    wait_drain();

    for (int ph = 0; ph < 6; ph++) begin
      program_all(ph == 5 ? 1 : 2);
      if (ph == 2) write_reg(rpar_pkg::REG_LIMITS, {32'hffff_ffff, 32'h0000_1000});
      add_random(300);
      wait_drain();
    end
    program_all(0);
    add_random(50);
    wait_drain();
    repeat (400) @(posedge clk);

    $display("Ran %0d ticks (%0d skipped) over reset, random and extreme gain/limit settings,",
             n_ticks, n_skips);
    $display("with random stalls on both sides; %0d results checked.", n_results);
    if (errors == 0 && accel_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/rpar_pkg.sv
design/rpar_div.sv
design/rpar_dpath.sv
design/rpar_ctrl.sv
design/rate_pid_with_actual_rates.sv
design/rpar_checker.sv
dv/tb_top.sv
